@@ hw/rtl/bcm_pkg.sv @@
package bcm_pkg;

  // curve_mode register codes
  localparam logic [2:0] MODE_LINEAR  = 3'd0;
  localparam logic [2:0] MODE_LOG     = 3'd1;
  localparam logic [2:0] MODE_SIGMOID = 3'd2;
  localparam logic [2:0] MODE_EXP     = 3'd3;
  localparam logic [2:0] MODE_INV_LOG = 3'd4;

  localparam int MODE_W = 3;

  // knot table selects
  localparam int NUM_CURVES = 4;
  localparam logic [1:0] CURVE_LOG     = 2'd0;
  localparam logic [1:0] CURVE_SIGMOID = 2'd1;
  localparam logic [1:0] CURVE_EXP     = 2'd2;
  localparam logic [1:0] CURVE_INV_LOG = 2'd3;

  // cycles from an accepted sample to its result strobe
  localparam int LATENCY = 5;

  localparam real EXP_SCALE = 1.0 / ($exp(3.0) - 1.0);

  // knot value round(f(t) * 2^frac_bits), clamped to 0..2^frac_bits
  function automatic int knot_value(logic [1:0] curve, real t, int frac_bits);
    real one;
    real f;
    real v;
    int  r;
    one = 2.0 ** frac_bits;
    case (curve)
      CURVE_LOG:     f = $log10(1.0 + 9.0 * t);
      CURVE_SIGMOID: f = 0.5 + 0.5 * $tanh(6.0 * (t - 0.5));
      CURVE_EXP:     f = ($exp(3.0 * t) - 1.0) * EXP_SCALE;
      CURVE_INV_LOG: f = 1.0 - $log10(10.0 - 9.0 * t);
      default:       f = t;
    endcase
    v = f * one + 0.5;
    if (v < 0.0) begin
      v = 0.0;
    end
    if (v > one) begin
      v = one;
    end
    r = $rtoi(v);
    return r;
  endfunction

endpackage

@@ hw/rtl/bcm_knot_rom.sv @@
module bcm_knot_rom
  import bcm_pkg::*;
#(
  parameter int SEGMENTS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic [1:0]                         curve,
  input  logic [$clog2(SEGMENTS + 1) - 1:0]  seg,
  output logic [FRAC_BITS:0]                 knot_lo_r,
  output logic [FRAC_BITS:0]                 knot_hi_r
);

  localparam int OUT_W = FRAC_BITS + 1;
  localparam int SEG_W = $clog2(SEGMENTS + 1);
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS);

  logic [OUT_W-1:0] knots_w [NUM_CURVES][SEGMENTS + 1];
  logic [SEG_W-1:0] seg_hi;

  // constant knot tables, worked out at elaboration
  for (genvar c = 0; c < NUM_CURVES; c++) begin : g_curve
    for (genvar k = 0; k <= SEGMENTS; k++) begin : g_knot
      localparam real T    = real'(k) / real'(SEGMENTS);
      localparam int  KNOT = knot_value(2'(c), T, FRAC_BITS);
      assign knots_w[c][k] = OUT_W'(KNOT);
    end
  end

  // upper knot; at the last knot the fraction is zero so reuse it
  assign seg_hi = (seg == SEG_LAST) ? seg : seg + SEG_W'(1);

  always_ff @(posedge clk) begin
    knot_lo_r <= knots_w[curve][seg];
    knot_hi_r <= knots_w[curve][seg_hi];
  end

endmodule

@@ hw/rtl/brightness_curve_map.sv @@
// brightness curve map: one signed Q2.16 progress sample is clamped to 0..1
// and shaped by the curve that curve_mode selects (linear, log, sigmoid,
// exponential, inverse log; unused codes act as linear). a sample can be
// transferred on every clock: start is taken whenever busy is low, and busy
// is high only while rst_n is asserted. the result shows up on out_curved
// with a one-cycle out_valid strobe after it has passed the pipeline stages,
// in order; the receiver has no way to hold it off, so it must take every
// strobe. the five stages are clamp, segment split (multiply by the
// segment count), knot table read, the two interpolation products, and
// the rounding add; the multiplier stage sets the clock. curve_mode is
// written through cfg_wr_en / cfg_wr_data and is sampled when a sample
// enters, so change it only with nothing in flight.
module brightness_curve_map
  import bcm_pkg::*;
#(
  parameter int SEGMENTS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample in
  input  logic                   start,
  output logic                   busy,
  input  logic [FRAC_BITS+1:0]   in_progress,
  // result out
  output logic                   out_valid,
  output logic [FRAC_BITS:0]     out_curved,
  // curve_mode register
  input  logic                   cfg_wr_en,
  input  logic [MODE_W-1:0]      cfg_wr_data
);

  localparam int IN_W   = FRAC_BITS + 2;
  localparam int OUT_W  = FRAC_BITS + 1;
  localparam int SEG_W  = $clog2(SEGMENTS + 1);
  localparam int P_W    = OUT_W + SEG_W;
  localparam int PROD_W = 2 * FRAC_BITS + 1;
  localparam int SUM_W  = 2 * FRAC_BITS + 2;

  localparam logic [OUT_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic              in_xfer;
  logic [MODE_W-1:0] curve_mode_r;
  logic [MODE_W-1:0] curve_mode_nxt;

  // stage 1: clamped sample and decoded curve
  logic             v1_r;
  logic [OUT_W-1:0] x1_r, x1_nxt;
  logic             rom1_r, rom1_nxt;
  logic [1:0]       curve1_r, curve1_nxt;

  // stage 2: segment and fraction
  logic             v2_r;
  logic [P_W-1:0]   p2;
  logic [SEG_W-1:0] seg2_r;
  logic [FRAC_BITS-1:0] fr2_r;
  logic [OUT_W-1:0] x2_r;
  logic             rom2_r;
  logic [1:0]       curve2_r;

  // stage 3: knots (registered inside the table)
  logic             v3_r;
  logic [OUT_W-1:0] knot_lo, knot_hi;
  logic [FRAC_BITS-1:0] fr3_r;
  logic [OUT_W-1:0] x3_r;
  logic             rom3_r;

  // stage 4: interpolation products
  logic             v4_r;
  logic [PROD_W-1:0] prod_lo_r, prod_hi_r;
  logic [OUT_W-1:0] x4_r;
  logic             rom4_r;

  // stage 5: output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_curved_r;
  logic [SUM_W-1:0] sum4;

  assign busy    = ~rst_n;
  assign in_xfer = start & ~busy;

  assign curve_mode_nxt = cfg_wr_en ? cfg_wr_data : curve_mode_r;

  // clamp: sign set goes to zero, anything past one saturates
  always_comb begin
    if (in_progress[IN_W-1]) begin
      x1_nxt = '0;
    end else if (in_progress[IN_W-2:0] > ONE) begin
      x1_nxt = ONE;
    end else begin
      x1_nxt = in_progress[IN_W-2:0];
    end
  end

  always_comb begin
    case (curve_mode_r)
      MODE_LOG: begin
        rom1_nxt   = 1'b1;
        curve1_nxt = CURVE_LOG;
      end
      MODE_SIGMOID: begin
        rom1_nxt   = 1'b1;
        curve1_nxt = CURVE_SIGMOID;
      end
      MODE_EXP: begin
        rom1_nxt   = 1'b1;
        curve1_nxt = CURVE_EXP;
      end
      MODE_INV_LOG: begin
        rom1_nxt   = 1'b1;
        curve1_nxt = CURVE_INV_LOG;
      end
      default: begin
        // linear and unused codes pass the clamped sample through
        rom1_nxt   = 1'b0;
        curve1_nxt = CURVE_LOG;
      end
    endcase
  end

  // position on the knot axis: integer part is the segment
  assign p2 = P_W'(x1_r) * P_W'(SEGMENTS);

  // rounding add of the two weighted knots
  assign sum4 = SUM_W'(prod_lo_r) + SUM_W'(prod_hi_r) + HALF;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= MODE_LINEAR;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      curve_mode_r <= curve_mode_nxt;
      v1_r         <= in_xfer;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      out_valid_r  <= v4_r;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    x1_r      <= x1_nxt;
    rom1_r    <= rom1_nxt;
    curve1_r  <= curve1_nxt;

    seg2_r    <= p2[FRAC_BITS +: SEG_W];
    fr2_r     <= p2[FRAC_BITS-1:0];
    x2_r      <= x1_r;
    rom2_r    <= rom1_r;
    curve2_r  <= curve1_r;

    fr3_r     <= fr2_r;
    x3_r      <= x2_r;
    rom3_r    <= rom2_r;

    prod_lo_r <= PROD_W'(knot_lo) * PROD_W'(ONE - OUT_W'(fr3_r));
    prod_hi_r <= PROD_W'(knot_hi) * PROD_W'(fr3_r);
    x4_r      <= x3_r;
    rom4_r    <= rom3_r;

    out_curved_r <= rom4_r ? sum4[FRAC_BITS +: OUT_W] : x4_r;
  end

  bcm_knot_rom #(
    .SEGMENTS  (SEGMENTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_knot_rom (
    .clk       (clk),
    .curve     (curve2_r),
    .seg       (seg2_r),
    .knot_lo_r (knot_lo),
    .knot_hi_r (knot_hi)
  );

  assign out_valid  = out_valid_r;
  assign out_curved = out_curved_r;

endmodule

@@ hw/rtl/bcm_checker.sv @@
module bcm_checker
  import bcm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [FRAC_BITS+1:0]   in_progress,
  input logic                   out_valid,
  input logic [FRAC_BITS:0]     out_curved,
  input logic                   cfg_wr_en,
  input logic [MODE_W-1:0]      cfg_wr_data
);

  localparam int IN_W  = FRAC_BITS + 2;
  localparam int OUT_W = FRAC_BITS + 1;
  localparam logic [OUT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic              xfer;
  logic [MODE_W-1:0] mode_r;
  logic              linear;
  logic [OUT_W-1:0]  clamp_exp;

  assign xfer = start & ~busy;

  // shadow of the mode register as seen on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINEAR;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign linear = !(mode_r inside {MODE_LOG, MODE_SIGMOID, MODE_EXP, MODE_INV_LOG});

  always_comb begin
    if (in_progress[IN_W-1]) begin
      clamp_exp = '0;
    end else if (in_progress[IN_W-2:0] > ONE) begin
      clamp_exp = ONE;
    end else begin
      clamp_exp = in_progress[IN_W-2:0];
    end
  end

  // every transfer is followed by a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> ##LATENCY out_valid)
    else $error("missing result strobe");

  // no strobe without a transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(xfer, LATENCY))
    else $error("result strobe without a transfer");

  // curves stay in 0..1
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_curved <= ONE))
    else $error("result above one");

  // linear mode returns the clamped sample
  a_linear: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && linear) |-> ##LATENCY (out_curved == $past(clamp_exp, LATENCY)))
    else $error("linear result mismatch");

endmodule

bind brightness_curve_map bcm_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_bcm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_progress (in_progress),
  .out_valid   (out_valid),
  .out_curved  (out_curved),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
